[src/tbik_pkg.sv]
// ----------------------------------------------------------------------------
// Two-bone IK solver package
// Shared widths, status codes, channel payloads and the per-item context
// that travels down the solver pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tbik_pkg;

   // Coordinate and length widths.
   localparam int COORD_BITS = 24;
   localparam int LEN_W      = 16;

   // Coordinate differences need one more bit than a coordinate.
   localparam int DIFF_W = COORD_BITS + 1;

   // Square root unit: radicand holds dx*dx + dy*dy, root holds the distance.
   localparam int ROOT_W    = DIFF_W;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SQR_REM_W = ROOT_W + 2;

   // Divider unit: rounded numerators, distance-sized divisors, and
   // quotients that stay below a few times the longest bone.
   localparam int QUO_W   = LEN_W + 3;
   localparam int NUM_W   = DIFF_W + LEN_W + 1;
   localparam int DEN_W   = ROOT_W;
   localparam int DIV_LANES = 2;

   // Signed projection length along the root-to-target line.
   localparam int A_W = QUO_W + 1;

   // Epsilon of the reach tests, one LSB.
   localparam int EPS_LSB = 1;

   typedef enum logic [1:0] {
      ST_SOLVED = 2'd0,
      ST_REACH  = 2'd1,
      ST_CLOSE  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] root_x;
      logic signed [COORD_BITS-1:0] root_y;
      logic signed [COORD_BITS-1:0] goal_x;
      logic signed [COORD_BITS-1:0] goal_y;
      logic [LEN_W-1:0]             upper_length;
      logic [LEN_W-1:0]             lower_length;
      logic                         bend_flip;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] joint_x;
      logic signed [COORD_BITS-1:0] joint_y;
      status_type                   solve_status;
   } rsp_type;

   // Everything an item still needs as it moves through the pipeline.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] rx;
      logic signed [COORD_BITS-1:0] ry;
      logic signed [DIFF_W-1:0]     dx;
      logic signed [DIFF_W-1:0]     dy;
      logic [LEN_W-1:0]             l1;
      logic [LEN_W-1:0]             l2;
      logic                         flip;
      logic [2*LEN_W-1:0]           l1sq;
      logic [2*LEN_W-1:0]           l2sq;
      logic [RAD_W-1:0]             d2;
      logic [ROOT_W-1:0]            d;
      status_type                   status;
      logic                         fail;
      logic                         near;
      logic                         num_neg;
      logic signed [A_W-1:0]        a;
      logic [LEN_W-1:0]             h;
      logic                         neg_x;
      logic                         neg_y;
   } ctx_type;

endpackage

`default_nettype wire

[src/two_bone_ik_joint_solver.sv]
// ----------------------------------------------------------------------------
// Two-bone IK joint solver
// Places the middle joint of a planar two-bone chain from a root, a target,
// two bone lengths and a bend side, with reach and closeness status.
// ----------------------------------------------------------------------------
// The solver takes one item per clock while req_stall is low and returns one
// result per item, in order. Its depth is set by the chain of bit-per-stage
// units: the distance square root, the division
// that finds the projection length, the square root of the perpendicular
// offset, and the final two-lane division by the distance. A two-entry
// output queue lets the pipeline keep taking items while a result waits;
// req_stall rises only when that queue is full, and the whole pipeline then
// holds until a result transfer frees an entry.
`default_nettype none

module two_bone_ik_joint_solver (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tbik_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tbik_pkg::rsp_type      rsp_data
);

   localparam int CW = tbik_pkg::COORD_BITS;
   localparam int DW = tbik_pkg::DIFF_W;
   localparam int LW = tbik_pkg::LEN_W;
   localparam int AW = tbik_pkg::A_W;
   localparam int RW = tbik_pkg::RAD_W;
   localparam int NW = tbik_pkg::NUM_W;
   localparam int QW = tbik_pkg::QUO_W;
   localparam int NSW = RW + 2;
   localparam int PW  = AW + DW + 1;
   localparam int JW  = CW + 2;
   localparam int H2W = 2 * AW + 1;

   logic en;

   // Stage 1: coordinate differences.
   logic              v1_ff;
   tbik_pkg::ctx_type c1_ff, c1_in;

   always_comb begin
      c1_in      = '0;
      c1_in.rx   = req_data.root_x;
      c1_in.ry   = req_data.root_y;
      c1_in.dx   = DW'(req_data.goal_x) - DW'(req_data.root_x);
      c1_in.dy   = DW'(req_data.goal_y) - DW'(req_data.root_y);
      c1_in.l1   = req_data.upper_length;
      c1_in.l2   = req_data.lower_length;
      c1_in.flip = req_data.bend_flip;
   end

   // Stage 2: squares of the differences and of the bone lengths.
   logic              v2_ff;
   tbik_pkg::ctx_type c2_ff, c2_in;
   logic [RW-1:0]     sx2_ff, sy2_ff;
   logic [DW-1:0]     ax, ay;

   always_comb begin
      ax         = c1_ff.dx[DW-1] ? DW'(-c1_ff.dx) : DW'(c1_ff.dx);
      ay         = c1_ff.dy[DW-1] ? DW'(-c1_ff.dy) : DW'(c1_ff.dy);
      c2_in      = c1_ff;
      c2_in.l1sq = c1_ff.l1 * c1_ff.l1;
      c2_in.l2sq = c1_ff.l2 * c1_ff.l2;
   end

   // Stage 3: squared distance.
   logic              v3_ff;
   tbik_pkg::ctx_type c3_ff, c3_in;
   logic [RW-1:0]     rad3_ff;

   always_comb begin
      c3_in    = c2_ff;
      c3_in.d2 = sx2_ff + sy2_ff;
   end

   // Distance square root.
   logic                       v4;
   logic [tbik_pkg::ROOT_W-1:0] d4;
   tbik_pkg::ctx_type          c4;

   tbik_sqrt u_dist_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (v3_ff),
      .rad_i  (rad3_ff),
      .ctx_i  (c3_ff),
      .vld_o  (v4),
      .root_o (d4),
      .ctx_o  (c4)
   );

   // Stage 5: reach tests and the law-of-cosines numerator.
   logic                   v5_ff;
   tbik_pkg::ctx_type      c5_ff, c5_in;
   logic signed [NSW-1:0]  num5_ff, num5_in;

   always_comb begin
      logic [LW:0]                     len_sum;
      logic [LW:0]                     len_diff;
      logic                            reach;
      logic                            close;
      len_sum  = (LW+1)'(c4.l1) + (LW+1)'(c4.l2);
      len_diff = (c4.l1 > c4.l2) ? (LW+1)'(c4.l1 - c4.l2) : (LW+1)'(c4.l2 - c4.l1);
      reach    = ((tbik_pkg::ROOT_W+1)'(d4) + (tbik_pkg::ROOT_W+1)'(tbik_pkg::EPS_LSB))
                 >= (tbik_pkg::ROOT_W+1)'(len_sum);
      close    = (tbik_pkg::ROOT_W+1)'(d4)
                 <= (tbik_pkg::ROOT_W+1)'(len_diff) + (tbik_pkg::ROOT_W+1)'(tbik_pkg::EPS_LSB);
      c5_in      = c4;
      c5_in.d    = d4;
      c5_in.fail = reach || close;
      c5_in.near = d4 <= tbik_pkg::ROOT_W'(tbik_pkg::EPS_LSB);
      if (reach) begin
         c5_in.status = tbik_pkg::ST_REACH;
      end else if (close) begin
         c5_in.status = tbik_pkg::ST_CLOSE;
      end else begin
         c5_in.status = tbik_pkg::ST_SOLVED;
      end
      num5_in = $signed(NSW'(c4.l1sq)) - $signed(NSW'(c4.l2sq)) + $signed(NSW'(c4.d2));
   end

   // Stage 6: rounded magnitude over twice the distance.
   logic                       v6_ff;
   tbik_pkg::ctx_type          c6_ff, c6_in;
   logic [NW-1:0]              numa6_ff, numa6_in;
   logic [tbik_pkg::DEN_W-1:0] dena6_ff, dena6_in;

   always_comb begin
      logic [NSW-1:0] mag;
      mag           = num5_ff[NSW-1] ? NSW'(-num5_ff) : NSW'(num5_ff);
      c6_in         = c5_ff;
      c6_in.num_neg = num5_ff[NSW-1];
      numa6_in      = mag[NW-1:0] + NW'(c5_ff.d);
      dena6_in      = {c5_ff.d[tbik_pkg::DEN_W-2:0], 1'b0};
   end

   // Projection length division; the second lane is idle.
   logic                                    v7;
   logic [tbik_pkg::DIV_LANES-1:0][QW-1:0]  qa7;
   tbik_pkg::ctx_type                       c7;
   logic [tbik_pkg::DIV_LANES-1:0][NW-1:0]  numa_lanes;

   assign numa_lanes = {NW'(0), numa6_ff};

   tbik_div u_proj_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vld_i (v6_ff),
      .num_i (numa_lanes),
      .den_i (dena6_ff),
      .ctx_i (c6_ff),
      .vld_o (v7),
      .quo_o (qa7),
      .ctx_o (c7)
   );

   // Stage 8: signed projection length.
   logic              v8_ff;
   tbik_pkg::ctx_type c8_ff, c8_in;

   always_comb begin
      c8_in   = c7;
      c8_in.a = c7.num_neg ? -$signed(AW'(qa7[0])) : $signed(AW'(qa7[0]));
   end

   // Stage 9: square of the projection length, at full product width.
   logic              v9_ff;
   tbik_pkg::ctx_type c9_ff;
   logic [2*AW-1:0]   asq9_ff, asq9_in;

   assign asq9_in = $unsigned((2*AW)'(c8_ff.a) * (2*AW)'(c8_ff.a));

   // Stage 10: squared perpendicular offset, clamped at zero.
   logic              v10_ff;
   tbik_pkg::ctx_type c10_ff;
   logic [RW-1:0]     rad10_ff, rad10_in;

   always_comb begin
      logic signed [H2W-1:0] h2;
      h2 = $signed(H2W'(c9_ff.l1sq)) - $signed(H2W'(asq9_ff));
      if (h2 > 0) begin
         rad10_in = RW'($unsigned(h2));
      end else begin
         rad10_in = '0;
      end
   end

   // Perpendicular offset square root.
   logic                        v11;
   logic [tbik_pkg::ROOT_W-1:0] h11;
   tbik_pkg::ctx_type           c11;

   tbik_sqrt u_offs_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (v10_ff),
      .rad_i  (rad10_ff),
      .ctx_i  (c10_ff),
      .vld_o  (v11),
      .root_o (h11),
      .ctx_o  (c11)
   );

   // Stage 12: products for both the solved and the failure placement.
   logic                      v12_ff;
   tbik_pkg::ctx_type         c12_ff, c12_in;
   logic signed [AW+DW-1:0]   pxa12_ff, pya12_ff;
   logic signed [LW+DW:0]     pxh12_ff, pyh12_ff, fx12_ff, fy12_ff;

   always_comb begin
      c12_in   = c11;
      c12_in.h = h11[LW-1:0];
   end

   // Stage 13: numerators of the joint offsets.
   logic                 v13_ff;
   tbik_pkg::ctx_type    c13_ff;
   logic signed [PW-1:0] nx13_ff, ny13_ff, nx13_in, ny13_in;

   always_comb begin
      if (c12_ff.fail) begin
         nx13_in = PW'(fx12_ff);
         ny13_in = PW'(fy12_ff);
      end else if (c12_ff.flip) begin
         nx13_in = PW'(pxa12_ff) + PW'(pxh12_ff);
         ny13_in = PW'(pya12_ff) - PW'(pyh12_ff);
      end else begin
         nx13_in = PW'(pxa12_ff) - PW'(pxh12_ff);
         ny13_in = PW'(pya12_ff) + PW'(pyh12_ff);
      end
   end

   // Stage 14: rounded magnitudes over the distance.
   logic                                   v14_ff;
   tbik_pkg::ctx_type                      c14_ff, c14_in;
   logic [tbik_pkg::DIV_LANES-1:0][NW-1:0] num14_ff, num14_in;

   always_comb begin
      logic [PW-1:0] mx;
      logic [PW-1:0] my;
      mx           = nx13_ff[PW-1] ? PW'(-nx13_ff) : PW'(nx13_ff);
      my           = ny13_ff[PW-1] ? PW'(-ny13_ff) : PW'(ny13_ff);
      c14_in       = c13_ff;
      c14_in.neg_x = nx13_ff[PW-1];
      c14_in.neg_y = ny13_ff[PW-1];
      num14_in[0]  = mx[NW-1:0] + NW'(c13_ff.d >> 1);
      num14_in[1]  = my[NW-1:0] + NW'(c13_ff.d >> 1);
   end

   // Joint offset division, x in lane 0 and y in lane 1.
   logic                                    v15;
   logic [tbik_pkg::DIV_LANES-1:0][QW-1:0]  q15;
   tbik_pkg::ctx_type                       c15;

   tbik_div u_joint_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vld_i (v14_ff),
      .num_i (num14_ff),
      .den_i (c14_ff.d),
      .ctx_i (c14_ff),
      .vld_o (v15),
      .quo_o (q15),
      .ctx_o (c15)
   );

   // Root if fail and near, else root+offset; saturate to coordinate range.
   tbik_pkg::rsp_type res;

   always_comb begin
      logic signed [QW:0]   qx;
      logic signed [QW:0]   qy;
      logic signed [JW-1:0] jx;
      logic signed [JW-1:0] jy;
      qx = c15.neg_x ? -$signed((QW+1)'(q15[0])) : $signed((QW+1)'(q15[0]));
      qy = c15.neg_y ? -$signed((QW+1)'(q15[1])) : $signed((QW+1)'(q15[1]));
      if (c15.fail && c15.near) begin
         jx = JW'(c15.rx);
         jy = JW'(c15.ry);
      end else begin
         jx = JW'(c15.rx) + JW'(qx);
         jy = JW'(c15.ry) + JW'(qy);
      end
      if (jx[JW-1:CW-1] == '0 || jx[JW-1:CW-1] == '1) begin
         res.joint_x = jx[CW-1:0];
      end else begin
         res.joint_x = {jx[JW-1], {(CW-1){~jx[JW-1]}}};
      end
      if (jy[JW-1:CW-1] == '0 || jy[JW-1:CW-1] == '1) begin
         res.joint_y = jy[CW-1:0];
      end else begin
         res.joint_y = {jy[JW-1], {(CW-1){~jy[JW-1]}}};
      end
      res.solve_status = c15.status;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= req_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v5_ff  <= v4;
         v6_ff  <= v5_ff;
         v8_ff  <= v7;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v12_ff <= v11;
         v13_ff <= v12_ff;
         v14_ff <= v13_ff;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff    <= c1_in;
         c2_ff    <= c2_in;
         sx2_ff   <= ax * ax;
         sy2_ff   <= ay * ay;
         c3_ff    <= c3_in;
         rad3_ff  <= c3_in.d2;
         c5_ff    <= c5_in;
         num5_ff  <= num5_in;
         c6_ff    <= c6_in;
         numa6_ff <= numa6_in;
         dena6_ff <= dena6_in;
         c8_ff    <= c8_in;
         c9_ff    <= c8_ff;
         asq9_ff  <= asq9_in;
         c10_ff   <= c9_ff;
         rad10_ff <= rad10_in;
         c12_ff   <= c12_in;
         pxa12_ff <= c11.a * c11.dx;
         pya12_ff <= c11.a * c11.dy;
         pxh12_ff <= $signed({1'b0, h11[LW-1:0]}) * c11.dy;
         pyh12_ff <= $signed({1'b0, h11[LW-1:0]}) * c11.dx;
         fx12_ff  <= $signed({1'b0, c11.l1}) * c11.dx;
         fy12_ff  <= $signed({1'b0, c11.l1}) * c11.dy;
         c13_ff   <= c12_ff;
         nx13_ff  <= nx13_in;
         ny13_ff  <= ny13_in;
         c14_ff   <= c14_in;
         num14_ff <= num14_in;
      end
   end

   // Two-entry result queue; the pipeline runs while it has a free entry.
   tbik_pkg::rsp_type fifo_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;
   logic              pop;

   assign en        = (cnt_ff != 2'd2);
   assign req_stall = ~en;
   assign push      = v15 && en;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

[src/tbik_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit square root, one result bit per register stage,
// with the item context carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tbik_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          vld_i,
   input  wire logic [tbik_pkg::RAD_W-1:0]    rad_i,
   input  wire tbik_pkg::ctx_type             ctx_i,
   output logic                               vld_o,
   output logic [tbik_pkg::ROOT_W-1:0]        root_o,
   output tbik_pkg::ctx_type                  ctx_o
);

   localparam int NS = tbik_pkg::ROOT_W;

   logic                               vld_ff  [NS];
   logic [tbik_pkg::SQR_REM_W-1:0]     rem_ff  [NS];
   logic [tbik_pkg::ROOT_W-1:0]        root_ff [NS];
   logic [tbik_pkg::RAD_W-1:0]         rad_ff  [NS];
   tbik_pkg::ctx_type                  ctx_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic                             vld_p;
      logic [tbik_pkg::SQR_REM_W-1:0]   rem_p;
      logic [tbik_pkg::ROOT_W-1:0]      root_p;
      logic [tbik_pkg::RAD_W-1:0]       rad_p;
      tbik_pkg::ctx_type                ctx_p;
      logic [tbik_pkg::SQR_REM_W+1:0]   trial;
      logic [tbik_pkg::SQR_REM_W+1:0]   test;
      logic [tbik_pkg::SQR_REM_W-1:0]   rem_in;
      logic [tbik_pkg::ROOT_W-1:0]      root_in;

      // Previous stage, or the unit's input for the first digit.
      if (k == 0) begin : g_first
         assign vld_p  = vld_i;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad_i;
         assign ctx_p  = ctx_i;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign ctx_p  = ctx_ff[k-1];
      end

      // Bring down the next bit pair and try to subtract 4*root+1.
      always_comb begin
         trial = {rem_p, rad_p[tbik_pkg::RAD_W-1 -: 2]};
         test  = (tbik_pkg::SQR_REM_W+2)'({root_p, 2'b01});
         if (trial >= test) begin
            rem_in  = tbik_pkg::SQR_REM_W'(trial - test);
            root_in = {root_p[tbik_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = tbik_pkg::SQR_REM_W'(trial);
            root_in = {root_p[tbik_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_p[tbik_pkg::RAD_W-3:0], 2'b00};
            ctx_ff[k]  <= ctx_p;
         end
      end
   end

   assign vld_o  = vld_ff[NS-1];
   assign root_o = root_ff[NS-1];
   assign ctx_o  = ctx_ff[NS-1];

endmodule

`default_nettype wire

[src/tbik_div.sv]
// ----------------------------------------------------------------------------
// Pipelined two-lane divider
// Restoring unsigned division of two numerators by one shared divisor, one
// quotient bit per register stage, with the item context carried alongside.
// The upper numerator bits must stay below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tbik_div (
   input  wire logic                                                   clock,
   input  wire logic                                                   reset,
   input  wire logic                                                   en,
   input  wire logic                                                   vld_i,
   input  wire logic [tbik_pkg::DIV_LANES-1:0][tbik_pkg::NUM_W-1:0]    num_i,
   input  wire logic [tbik_pkg::DEN_W-1:0]                             den_i,
   input  wire tbik_pkg::ctx_type                                      ctx_i,
   output logic                                                        vld_o,
   output logic [tbik_pkg::DIV_LANES-1:0][tbik_pkg::QUO_W-1:0]         quo_o,
   output tbik_pkg::ctx_type                                           ctx_o
);

   localparam int NS = tbik_pkg::QUO_W;
   localparam int NL = tbik_pkg::DIV_LANES;

   logic                                           vld_ff [NS];
   logic [tbik_pkg::DEN_W-1:0]                     den_ff [NS];
   logic [NL-1:0][tbik_pkg::DEN_W-1:0]             par_ff [NS];
   logic [NL-1:0][tbik_pkg::QUO_W-1:0]             quo_ff [NS];
   logic [NL-1:0][tbik_pkg::QUO_W-1:0]             low_ff [NS];
   tbik_pkg::ctx_type                              ctx_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic                                  vld_p;
      logic [tbik_pkg::DEN_W-1:0]            den_p;
      logic [NL-1:0][tbik_pkg::DEN_W-1:0]    par_p;
      logic [NL-1:0][tbik_pkg::QUO_W-1:0]    quo_p;
      logic [NL-1:0][tbik_pkg::QUO_W-1:0]    low_p;
      tbik_pkg::ctx_type                     ctx_p;
      logic [NL-1:0][tbik_pkg::DEN_W-1:0]    par_in;
      logic [NL-1:0][tbik_pkg::QUO_W-1:0]    quo_in;
      logic [NL-1:0][tbik_pkg::QUO_W-1:0]    low_in;

      // Previous stage, or the unit's input for the first quotient bit.
      if (k == 0) begin : g_first
         assign vld_p = vld_i;
         assign den_p = den_i;
         assign ctx_p = ctx_i;
         for (genvar l = 0; l < NL; l++) begin : g_lane
            assign par_p[l] = tbik_pkg::DEN_W'(num_i[l][tbik_pkg::NUM_W-1:tbik_pkg::QUO_W]);
            assign low_p[l] = num_i[l][tbik_pkg::QUO_W-1:0];
            assign quo_p[l] = '0;
         end
      end else begin : g_next
         assign vld_p = vld_ff[k-1];
         assign den_p = den_ff[k-1];
         assign ctx_p = ctx_ff[k-1];
         assign par_p = par_ff[k-1];
         assign low_p = low_ff[k-1];
         assign quo_p = quo_ff[k-1];
      end

      // Shift in the next numerator bit and subtract the divisor if it fits.
      always_comb begin
         logic [tbik_pkg::DEN_W:0] trial;
         for (int l = 0; l < NL; l++) begin
            trial = {par_p[l], low_p[l][tbik_pkg::QUO_W-1]};
            if (trial >= {1'b0, den_p}) begin
               par_in[l] = tbik_pkg::DEN_W'(trial - {1'b0, den_p});
               quo_in[l] = {quo_p[l][tbik_pkg::QUO_W-2:0], 1'b1};
            end else begin
               par_in[l] = tbik_pkg::DEN_W'(trial);
               quo_in[l] = {quo_p[l][tbik_pkg::QUO_W-2:0], 1'b0};
            end
            low_in[l] = {low_p[l][tbik_pkg::QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= den_p;
            par_ff[k] <= par_in;
            quo_ff[k] <= quo_in;
            low_ff[k] <= low_in;
            ctx_ff[k] <= ctx_p;
         end
      end
   end

   assign vld_o = vld_ff[NS-1];
   assign quo_o = quo_ff[NS-1];
   assign ctx_o = ctx_ff[NS-1];

endmodule

`default_nettype wire
